### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the window likelihood rtl, off under SYNTH
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define WLPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WLPA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WLPA_ASSERT(lbl, prop, msg)
`define WLPA_NEVER(lbl, cond, msg)
`endif

`endif

### hw/rtl/wlpa_pkg.sv
// ---------------------------------------------------------------------------
// wlpa_pkg
// shared constants, codes and types of the window likelihood product unit
// ---------------------------------------------------------------------------
package wlpa_pkg;

    localparam int HALF_WIDTH_DEF     = 8;
    localparam int PROB_FRAC_BITS_DEF = 16;
    localparam int CELL_W_DEF         = $clog2(2 * HALF_WIDTH_DEF + 1);
    localparam int PROB_W_DEF         = PROB_FRAC_BITS_DEF + 1;

    localparam int CENTRE_W   = 10;
    localparam int POS_W      = 12;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ACC   = 2'd1;
    localparam logic [1:0] FUNC_SCORE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [0:0] {
        SW_RUN,
        SW_CLEAR
    } sweep_state_t;

    typedef struct packed {
        logic busy;
        logic wr_en;
    } sweep_ctl_t;

endpackage

### hw/rtl/wlpa_if.sv
// ---------------------------------------------------------------------------
// wlpa_if
// valid/ready channels for cell items and score results
// ---------------------------------------------------------------------------
interface wlpa_in_if #(
    parameter int CELL_W = wlpa_pkg::CELL_W_DEF,
    parameter int PROB_W = wlpa_pkg::PROB_W_DEF
) ();
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [PROB_W-1:0] prob;
    logic              in_map;
    logic              has_extra;
    logic              last;

    modport source (
        output valid, func, cell_x, cell_y, prob, in_map, has_extra, last,
        input  ready
    );
    modport sink (
        input  valid, func, cell_x, cell_y, prob, in_map, has_extra, last,
        output ready
    );
endinterface

interface wlpa_out_if #(
    parameter int PROB_W = wlpa_pkg::PROB_W_DEF
) ();
    logic                               valid;
    logic                               ready;
    logic [PROB_W-1:0]                  best_score;
    logic signed [wlpa_pkg::POS_W-1:0]  best_x;
    logic signed [wlpa_pkg::POS_W-1:0]  best_y;
    logic [wlpa_pkg::COUNT_W-1:0]       view_count;

    modport source (
        output valid, best_score, best_x, best_y, view_count,
        input  ready
    );
    modport sink (
        input  valid, best_score, best_x, best_y, view_count,
        output ready
    );
endinterface

### hw/rtl/window_likelihood_product_argmax_unit.sv
// ---------------------------------------------------------------------------
// window_likelihood_product_argmax_unit
// window of likelihood cells in ram, multiplied per view and scanned for max
// ---------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | func, cell_x, cell_y, prob, in_map,
//           |     |               | has_extra, last
//  out_ch   | out | valid / ready | best_score, best_x, best_y, view_count
//  cfg      | in  | cfg_we        | cfg_idx, cfg_data
//
//  one item per cycle while ready is high: ram read, multiply, then write back or compare
//  a result is pushed into the result queue from stage 2 with the last score item
//  reset and every clear item load 1.0 into all (2*HALF_WIDTH+1)^2 cells,
//  one cell per cycle; no item is taken meanwhile
//  a four-entry result queue absorbs output stalls; input holds off when
//  queued results plus items in flight reach four
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module window_likelihood_product_argmax_unit #(
    parameter int HALF_WIDTH     = wlpa_pkg::HALF_WIDTH_DEF,
    parameter int PROB_FRAC_BITS = wlpa_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wlpa_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [wlpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    wlpa_in_if.sink                             in_ch,
    wlpa_out_if.source                          out_ch
);
    import wlpa_pkg::*;

    localparam int WIN    = 2 * HALF_WIDTH + 1;
    localparam int DEPTH  = WIN * WIN;
    localparam int AW     = $clog2(DEPTH);
    localparam int CELL_W = $clog2(WIN);
    localparam int PROB_W = PROB_FRAC_BITS + 1;
    localparam int PROD_W = 2 * PROB_W;
    localparam int OUT_W  = PROB_W + 2 * POS_W + COUNT_W;

    localparam logic [PROB_W-1:0] ONE     = {1'b1, {PROB_FRAC_BITS{1'b0}}};
    localparam logic [CELL_W-1:0] WIN_C   = CELL_W'(WIN);
    localparam logic [POS_W-1:0]  HALF_C  = POS_W'(HALF_WIDTH);

    // configuration
    logic [CENTRE_W-1:0] centre_x_reg;
    logic [CENTRE_W-1:0] centre_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CENTRE_X: centre_x_reg <= cfg_data;
                REG_CENTRE_Y: centre_y_reg <= cfg_data;
                default:      centre_x_reg <= centre_x_reg;
            endcase
        end
    end

    // stage registers
    logic              s1_valid_reg;
    logic [1:0]        s1_func_reg;
    logic              s1_ok_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [PROB_W-1:0] s1_prob_reg;
    logic              s1_inb_reg;
    logic              s1_extra_reg;
    logic              s1_last_reg;
    logic [CELL_W-1:0] s1_cx_reg;
    logic [CELL_W-1:0] s1_cy_reg;

    logic              s2_valid_reg;
    logic [1:0]        s2_func_reg;
    logic              s2_ok_reg;
    logic [AW-1:0]     s2_addr_reg;
    logic              s2_inb_reg;
    logic              s2_extra_reg;
    logic              s2_last_reg;
    logic [CELL_W-1:0] s2_cx_reg;
    logic [CELL_W-1:0] s2_cy_reg;
    logic [PROB_W-1:0] s2_val_reg;
    logic [PROB_W-1:0] s2_val_next;

    logic              lw_valid_reg;
    logic [AW-1:0]     lw_addr_reg;
    logic [PROB_W-1:0] lw_data_reg;

    logic [COUNT_W-1:0] views_reg;
    logic [COUNT_W-1:0] views_next;
    logic               scan_open_reg;
    logic               scan_open_next;
    logic [PROB_W-1:0]  scan_best_reg;
    logic [PROB_W-1:0]  scan_best_next;
    logic [POS_W-1:0]   scan_x_reg;
    logic [POS_W-1:0]   scan_x_next;
    logic [POS_W-1:0]   scan_y_reg;
    logic [POS_W-1:0]   scan_y_next;

    // input side
    logic              in_accept;
    logic              in_ok;
    logic [AW-1:0]     in_addr;
    logic [PROB_W-1:0] in_prob_sat;
    logic [OUT_CNT_W:0] occupancy;
    logic [OUT_CNT_W-1:0] fifo_count;

    sweep_ctl_t    sweep_ctl;
    logic [AW-1:0] sweep_addr;
    logic          s1_clear;
    logic          s2_clear;

    assign s1_clear = s1_valid_reg && (s1_func_reg == FUNC_CLEAR);
    assign s2_clear = s2_valid_reg && (s2_func_reg == FUNC_CLEAR);

    assign occupancy = (OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_valid_reg)
                       + (OUT_CNT_W + 1)'(s2_valid_reg);
    assign in_ch.ready = !sweep_ctl.busy && !s1_clear && !s2_clear
                         && (occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign in_accept = in_ch.valid && in_ch.ready;

    assign in_ok = (in_ch.cell_x < WIN_C) && (in_ch.cell_y < WIN_C);
    assign in_addr = in_ok ? AW'(in_ch.cell_y) * AW'(WIN) + AW'(in_ch.cell_x) : '0;
    assign in_prob_sat = (in_ch.prob > ONE) ? ONE : in_ch.prob;

    // cell memory
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PROB_W-1:0] ram_wdata;
    logic [PROB_W-1:0] ram_rdata;
    logic              s2_we;

    assign s2_we     = s2_valid_reg && (s2_func_reg == FUNC_ACC) && s2_ok_reg;
    assign ram_we    = sweep_ctl.wr_en || s2_we;
    assign ram_waddr = sweep_ctl.wr_en ? sweep_addr : s2_addr_reg;
    assign ram_wdata = sweep_ctl.wr_en ? ONE : s2_val_reg;

    wlpa_ram #(
        .WIDTH (PROB_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    wlpa_sweep #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s2_clear),
        .ctl   (sweep_ctl),
        .addr  (sweep_addr)
    );

    // stage 1: forward, multiply
    logic [PROB_W-1:0] cur_val;
    logic [PROD_W-1:0] prod_full;
    logic [PROB_W-1:0] prod_q;

    always_comb
    begin
        if (s2_we && (s2_addr_reg == s1_addr_reg))
        begin
            cur_val = s2_val_reg;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_addr_reg))
        begin
            cur_val = lw_data_reg;
        end
        else
        begin
            cur_val = ram_rdata;
        end
    end

    assign prod_full = PROD_W'(cur_val) * PROD_W'(s1_prob_reg);
    assign prod_q    = prod_full[PROB_FRAC_BITS +: PROB_W];

    always_comb
    begin
        if (s1_func_reg == FUNC_ACC)
        begin
            s2_val_next = s1_inb_reg ? prod_q : '0;
        end
        else
        begin
            s2_val_next = s1_extra_reg ? prod_q : cur_val;
        end
    end

    // stage 2: write back, compare, count views
    logic              s2_score;
    logic              s2_take;
    logic [PROB_W-1:0] base_best;
    logic [POS_W-1:0]  base_x;
    logic [POS_W-1:0]  base_y;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              res_push;
    logic [PROB_W-1:0]  res_score;
    logic [POS_W-1:0]   res_x;
    logic [POS_W-1:0]   res_y;
    logic [COUNT_W-1:0] res_count;

    assign s2_score  = s2_valid_reg && (s2_func_reg == FUNC_SCORE);
    assign base_best = scan_open_reg ? scan_best_reg : '0;
    assign base_x    = scan_open_reg ? scan_x_reg : '1;
    assign base_y    = scan_open_reg ? scan_y_reg : '1;
    assign pos_x     = POS_W'(centre_x_reg) + POS_W'(s2_cx_reg) - HALF_C;
    assign pos_y     = POS_W'(centre_y_reg) + POS_W'(s2_cy_reg) - HALF_C;
    assign s2_take   = s2_score && s2_ok_reg && !(s2_extra_reg && !s2_inb_reg)
                       && (s2_val_reg > base_best);

    always_comb
    begin
        views_next     = views_reg;
        scan_open_next = scan_open_reg;
        scan_best_next = scan_best_reg;
        scan_x_next    = scan_x_reg;
        scan_y_next    = scan_y_reg;
        if (s2_clear)
        begin
            views_next     = '0;
            scan_open_next = 1'b0;
        end
        else if (s2_valid_reg && (s2_func_reg == FUNC_ACC))
        begin
            if (s2_last_reg && (views_reg != COUNT_MAX))
            begin
                views_next = views_reg + COUNT_W'(1);
            end
        end
        else if (s2_score)
        begin
            scan_open_next = !s2_last_reg;
            scan_best_next = s2_take ? s2_val_reg : base_best;
            scan_x_next    = s2_take ? pos_x : base_x;
            scan_y_next    = s2_take ? pos_y : base_y;
        end
    end

    assign res_push = s2_score && s2_last_reg;

    always_comb
    begin
        if (views_reg == '0)
        begin
            res_score = '0;
            res_x     = '1;
            res_y     = '1;
            res_count = '0;
        end
        else
        begin
            res_score = scan_best_next;
            res_x     = scan_x_next;
            res_y     = scan_y_next;
            res_count = (s2_extra_reg && (views_reg != COUNT_MAX))
                        ? views_reg + COUNT_W'(1) : views_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            views_reg     <= '0;
            scan_open_reg <= 1'b0;
            scan_best_reg <= '0;
            scan_x_reg    <= '1;
            scan_y_reg    <= '1;
        end
        else
        begin
            s1_valid_reg  <= in_accept;
            s2_valid_reg  <= s1_valid_reg;
            lw_valid_reg  <= ram_we;
            views_reg     <= views_next;
            scan_open_reg <= scan_open_next;
            scan_best_reg <= scan_best_next;
            scan_x_reg    <= scan_x_next;
            scan_y_reg    <= scan_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= in_ch.func;
            s1_ok_reg    <= in_ok;
            s1_addr_reg  <= in_addr;
            s1_prob_reg  <= in_prob_sat;
            s1_inb_reg   <= in_ch.in_map;
            s1_extra_reg <= in_ch.has_extra;
            s1_last_reg  <= in_ch.last;
            s1_cx_reg    <= in_ch.cell_x;
            s1_cy_reg    <= in_ch.cell_y;
        end
        s2_func_reg  <= s1_func_reg;
        s2_ok_reg    <= s1_ok_reg;
        s2_addr_reg  <= s1_addr_reg;
        s2_inb_reg   <= s1_inb_reg;
        s2_extra_reg <= s1_extra_reg;
        s2_last_reg  <= s1_last_reg;
        s2_cx_reg    <= s1_cx_reg;
        s2_cy_reg    <= s1_cy_reg;
        s2_val_reg   <= s2_val_next;
        lw_addr_reg  <= ram_waddr;
        lw_data_reg  <= ram_wdata;
    end

    // result queue
    logic [OUT_W-1:0] push_data;
    logic [OUT_W-1:0] pop_data;

    assign push_data = {res_score, res_x, res_y, res_count};

    wlpa_out_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH),
        .CW    (OUT_CNT_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (push_data),
        .pop_valid (out_ch.valid),
        .pop_ready (out_ch.ready),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign out_ch.best_score = pop_data[OUT_W-1 -: PROB_W];
    assign out_ch.best_x     = $signed(pop_data[2 * POS_W + COUNT_W - 1 -: POS_W]);
    assign out_ch.best_y     = $signed(pop_data[POS_W + COUNT_W - 1 -: POS_W]);
    assign out_ch.view_count = pop_data[COUNT_W-1:0];

    `WLPA_ASSERT(a_clear_sweeps, s2_clear |=> sweep_ctl.busy, "clear did not start sweep")
    `WLPA_NEVER(a_no_write_clash, sweep_ctl.busy && s2_we, "cell write during sweep")
    `WLPA_NEVER(a_credit, occupancy > (OUT_CNT_W + 1)'(OUT_DEPTH), "results exceed queue room")
endmodule

### hw/rtl/wlpa_ram.sv
// ---------------------------------------------------------------------------
// wlpa_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module wlpa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 289,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/wlpa_sweep.sv
// ---------------------------------------------------------------------------
// wlpa_sweep
// walks every cell address once to load 1.0 after reset or a clear item
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wlpa_sweep #(
    parameter int DEPTH = 289,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output wlpa_pkg::sweep_ctl_t ctl,
    output logic [AW-1:0]        addr
);
    import wlpa_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    sweep_state_t  state_reg;
    sweep_state_t  state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SW_RUN:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = SW_CLEAR;
                end
            end
            SW_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = SW_RUN;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = SW_RUN;
            end
        endcase
    end

    always_comb
    begin
        ctl.busy  = 1'b0;
        ctl.wr_en = 1'b0;
        unique case (state_reg)
            SW_RUN:
            begin
                ctl.busy  = 1'b0;
                ctl.wr_en = 1'b0;
            end
            SW_CLEAR:
            begin
                ctl.busy  = 1'b1;
                ctl.wr_en = 1'b1;
            end
            default:
            begin
                ctl.busy  = 1'b0;
                ctl.wr_en = 1'b0;
            end
        endcase
    end

    assign addr = cnt_reg;

    `WLPA_ASSERT(a_sweep_full, (ctl.busy && cnt_reg != LAST_ADDR) |=> ctl.busy, "sweep ended early")
endmodule

### hw/rtl/wlpa_out_fifo.sv
// ---------------------------------------------------------------------------
// wlpa_out_fifo
// small result queue between the scan stage and the output channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wlpa_out_fifo #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 4,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data,
    output logic [CW-1:0]    count
);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop;

    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = data_reg[rd_ptr_reg];
    assign count     = count_reg;

    `WLPA_NEVER(a_fifo_overflow, push && !pop && count_reg == FULL_CNT, "result queue overflow")
endmodule

### bench/window_likelihood_product_argmax_unit_tb.sv
// ---------------------------------------------------------------------------
// window_likelihood_product_argmax_unit_tb
// drives clear, accumulate and score items into the window unit, predicts each
// score result with an in-bench window model and checks every result field;
// covers directed corner cases, count saturation, centre extremes, output
// back-pressure and four phases of random view and scan sequences
// ---------------------------------------------------------------------------
module window_likelihood_product_argmax_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wlpa_pkg::*;

    localparam int             HALF = HALF_WIDTH_DEF;
    localparam int             WIN  = 2 * HALF + 1;
    localparam int             FRAC = PROB_FRAC_BITS_DEF;
    localparam int             PW   = PROB_W_DEF;
    localparam int             CW   = CELL_W_DEF;
    localparam logic [PW-1:0]  ONE  = PW'(1) << FRAC;
    localparam logic [1:0]     FUNC_NONE = 2'd3;
    localparam int             SWEEP_WAIT = WIN * WIN + 16;

    typedef struct packed {
        logic [1:0]    func;
        logic [CW-1:0] cell_x;
        logic [CW-1:0] cell_y;
        logic [PW-1:0] prob;
        logic          in_map;
        logic          has_extra;
        logic          last;
    } cell_item_t;

    typedef struct packed {
        logic [PW-1:0]           score;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [COUNT_W-1:0]      count;
    } score_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wlpa_in_if  in_ch ();
    wlpa_out_if out_ch ();

    window_likelihood_product_argmax_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // window model
    logic [PW-1:0]         win_cells [WIN*WIN];
    logic [COUNT_W-1:0]    views_seen;
    logic [PW-1:0]         run_best;
    int                    run_best_x;
    int                    run_best_y;
    bit                    scan_open;
    logic [CENTRE_W-1:0]   centre_x;
    logic [CENTRE_W-1:0]   centre_y;

    score_t expected_scores [$];
    int     errors;
    int     cells_sent;
    bit     src_idle_on;
    bit     sink_idle_on;
    bit     sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    task automatic fill_window();
        foreach (win_cells[i])
            win_cells[i] = ONE;
    endtask

    task automatic predict_cell(input cell_item_t it);
        logic [PW-1:0]      p;
        logic [2*PW-1:0]    prod;
        logic [PW-1:0]      val;
        logic [COUNT_W:0]   n;
        bit                 in_win;
        int                 idx;
        int                 px;
        int                 py;
        score_t             r;
        p      = (it.prob > ONE) ? ONE : it.prob;
        in_win = (it.cell_x < WIN) && (it.cell_y < WIN);
        idx    = in_win ? int'(it.cell_y) * WIN + int'(it.cell_x) : 0;
        case (it.func)
            FUNC_CLEAR:
            begin
                fill_window();
                views_seen = '0;
                scan_open  = 1'b0;
            end
            FUNC_ACC:
            begin
                if (in_win)
                begin
                    if (!it.in_map)
                        win_cells[idx] = '0;
                    else
                    begin
                        prod           = win_cells[idx] * p;
                        win_cells[idx] = prod[FRAC +: PW];
                    end
                end
                if (it.last && views_seen != COUNT_MAX)
                    views_seen++;
            end
            FUNC_SCORE:
            begin
                if (!scan_open)
                begin
                    run_best   = '0;
                    run_best_x = -1;
                    run_best_y = -1;
                    scan_open  = 1'b1;
                end
                if (in_win && !(it.has_extra && !it.in_map))
                begin
                    val = win_cells[idx];
                    if (it.has_extra)
                    begin
                        prod = val * p;
                        val  = prod[FRAC +: PW];
                    end
                    if (val > run_best)
                    begin
                        run_best   = val;
                        run_best_x = int'(centre_x) + int'(it.cell_x) - HALF;
                        run_best_y = int'(centre_y) + int'(it.cell_y) - HALF;
                    end
                end
                if (it.last)
                begin
                    scan_open = 1'b0;
                    if (views_seen == 0)
                    begin
                        r.score = '0;
                        r.pos_x = '1;
                        r.pos_y = '1;
                        r.count = '0;
                    end
                    else
                    begin
                        n       = views_seen + it.has_extra;
                        r.count = (n > COUNT_MAX) ? COUNT_MAX : n[COUNT_W-1:0];
                        r.score = run_best;
                        px      = run_best_x;
                        py      = run_best_y;
                        r.pos_x = px[POS_W-1:0];
                        r.pos_y = py[POS_W-1:0];
                    end
                    expected_scores.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_cell(input logic [1:0] func, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [PW-1:0] prob,
                             input logic inb, input logic extra, input logic last);
        cell_item_t it;
        int         gap;
        it  = '{func, cx, cy, prob, inb, extra, last};
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= it.func;
        in_ch.cell_x    <= it.cell_x;
        in_ch.cell_y    <= it.cell_y;
        in_ch.prob      <= it.prob;
        in_ch.in_map    <= it.in_map;
        in_ch.has_extra <= it.has_extra;
        in_ch.last      <= it.last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_cell(it);
        cells_sent++;
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_scores.size() != 0);
    endtask

    task automatic set_centre(input logic [CENTRE_W-1:0] x, input logic [CENTRE_W-1:0] y);
        wait_results();
        repeat (SWEEP_WAIT) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_CENTRE_X;
        cfg_data <= x;
        @(posedge clk);
        centre_x = x;
        cfg_idx  <= REG_CENTRE_Y;
        cfg_data <= y;
        @(posedge clk);
        centre_y = y;
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [CW-1:0] pick_cell();
        if ($urandom_range(0, 9) == 0)
            return CW'($urandom_range(WIN, 31));
        return CW'($urandom_range(0, WIN - 1));
    endfunction

    function automatic logic [PW-1:0] pick_prob();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return ONE;
        if (sel == 3)
            return PW'($urandom_range(int'(ONE) + 1, (1 << PW) - 1));
        return PW'($urandom_range(0, int'(ONE)));
    endfunction

    task automatic send_view();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_cell(FUNC_ACC, pick_cell(), pick_cell(), pick_prob(),
                      $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), i == n - 1);
    endtask

    task automatic send_scan();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_cell(FUNC_SCORE, pick_cell(), pick_cell(), pick_prob(),
                      $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)), i == n - 1);
    endtask

    // checks each result against the oldest prediction
    task automatic check_score();
        score_t want;
        if (expected_scores.size() == 0)
        begin
            report_mismatch("unexpected result, score", out_ch.best_score, -1);
            return;
        end
        want = expected_scores.pop_front();
        if (out_ch.best_score !== want.score)
            report_mismatch("best_score", out_ch.best_score, want.score);
        if (out_ch.best_x !== want.pos_x)
            report_mismatch("best_x", out_ch.best_x, want.pos_x);
        if (out_ch.best_y !== want.pos_y)
            report_mismatch("best_y", out_ch.best_y, want.pos_y);
        if (out_ch.view_count !== want.count)
            report_mismatch("view_count", out_ch.view_count, want.count);
    endtask

    initial
    begin : result_sink
        int sink_wait;
        sink_wait = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                check_score();
                sink_wait = sink_idle_on ? $urandom_range(0, 3) : 0;
            end
            else if (sink_wait > 0)
                sink_wait--;
            out_ch.ready <= (sink_wait == 0) && !sink_hold;
        end
    end

    task automatic hold_results(input int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    task automatic test_reset_scan();
        send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_SCORE, 5'd16, 5'd16, ONE, 1'b1, 1'b1, 1'b1);
        wait_results();
    endtask

    task automatic test_view_products();
        send_cell(FUNC_ACC, 5'd0, 5'd0, ONE, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_ACC, 5'd16, 5'd16, 17'h1FFFF, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_ACC, 5'd8, 5'd8, 17'h08000, 1'b1, 1'b1, 1'b0);
        send_cell(FUNC_ACC, 5'd3, 5'd4, ONE, 1'b0, 1'b0, 1'b0);
        send_cell(FUNC_ACC, 5'd31, 5'd17, 17'd100, 1'b1, 1'b0, 1'b1);
        // out-of-bounds extra view skips the brightest cell
        send_cell(FUNC_SCORE, 5'd3, 5'd4, 17'd0, 1'b0, 1'b0, 1'b0);
        send_cell(FUNC_SCORE, 5'd16, 5'd16, ONE, 1'b0, 1'b1, 1'b0);
        send_cell(FUNC_SCORE, 5'd8, 5'd8, 17'h1FFFF, 1'b1, 1'b1, 1'b0);
        send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b1, 1'b0);
        send_cell(FUNC_SCORE, 5'd17, 5'd31, ONE, 1'b1, 1'b1, 1'b1);
        // tie keeps the first cell
        send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0);
        send_cell(FUNC_SCORE, 5'd16, 5'd16, 17'd0, 1'b0, 1'b0, 1'b1);
        wait_results();
    endtask

    task automatic test_open_scan();
        send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_ACC, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_NONE, 5'd1, 5'd1, 17'h1FFFF, 1'b1, 1'b1, 1'b1);
        send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b1);
        send_cell(FUNC_SCORE, 5'd5, 5'd5, 17'd0, 1'b1, 1'b0, 1'b0);
        send_cell(FUNC_CLEAR, 5'd0, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0);
        send_cell(FUNC_SCORE, 5'd5, 5'd5, 17'd0, 1'b1, 1'b0, 1'b1);
        wait_results();
    endtask

    task automatic test_count_saturation();
        src_idle_on = 1'b0;
        send_cell(FUNC_CLEAR, 5'd0, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0);
        repeat (int'(COUNT_MAX) + 1)
            send_cell(FUNC_ACC, 5'd31, 5'd2, ONE, 1'b1, 1'b0, 1'b1);
        send_cell(FUNC_SCORE, 5'd8, 5'd8, 17'd0, 1'b1, 1'b0, 1'b1);
        send_cell(FUNC_SCORE, 5'd8, 5'd8, ONE, 1'b1, 1'b1, 1'b1);
        src_idle_on = 1'b1;
        wait_results();
    endtask

    task automatic test_centre_extremes();
        logic [CENTRE_W-1:0] top;
        top = '1;
        for (int k = 0; k < 4; k++)
        begin
            set_centre(k[0] ? top : '0, k[1] ? top : '0);
            send_cell(FUNC_CLEAR, 5'd0, 5'd0, 17'd0, 1'b0, 1'b0, 1'b0);
            send_cell(FUNC_ACC, 5'd8, 5'd8, 17'd0, 1'b1, 1'b0, 1'b1);
            send_cell(FUNC_SCORE, 5'd8, 5'd8, 17'd0, 1'b1, 1'b0, 1'b0);
            send_cell(FUNC_SCORE, 5'd16, 5'd16, 17'd0, 1'b1, 1'b0, 1'b0);
            send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b1);
            send_cell(FUNC_SCORE, 5'd0, 5'd0, 17'd0, 1'b1, 1'b0, 1'b1);
            wait_results();
        end
    endtask

    task automatic test_backpressure();
        send_view();
        src_idle_on = 1'b0;
        fork
            hold_results(200);
        join_none
        repeat (16)
            send_cell(FUNC_SCORE, pick_cell(), pick_cell(), pick_prob(), 1'b1,
                      1'($urandom_range(0, 1)), 1'b1);
        src_idle_on = 1'b1;
        wait_results();
        repeat (8)
            send_cell(FUNC_SCORE, pick_cell(), pick_cell(), pick_prob(), 1'b1, 1'b0, 1'b1);
        wait_results();
    endtask

    task automatic test_random();
        int phase_start;
        int n;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_centre(CENTRE_W'($urandom_range(0, 1023)), CENTRE_W'($urandom_range(0, 1023)));
            phase_start = cells_sent;
            while (cells_sent - phase_start < 24)
            begin
                src_idle_on  = $urandom_range(0, 3) != 0;
                sink_idle_on <= $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 99) < 15)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_cell(2'($urandom_range(0, 3)), CW'($urandom_range(0, 31)),
                                  CW'($urandom_range(0, 31)),
                                  PW'($urandom_range(0, (1 << PW) - 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_cell(FUNC_CLEAR, pick_cell(), pick_cell(), pick_prob(),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_view();
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_scan();
                end
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on <= 1'b1;
        wait_results();
    endtask

    initial
    begin
        errors          = 0;
        cells_sent      = 0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        sink_hold       = 1'b0;
        rst_n           = 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_CENTRE_X;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FUNC_CLEAR;
        in_ch.cell_x    <= '0;
        in_ch.cell_y    <= '0;
        in_ch.prob      <= '0;
        in_ch.in_map    <= 1'b0;
        in_ch.has_extra <= 1'b0;
        in_ch.last      <= 1'b0;
        fill_window();
        views_seen = '0;
        run_best   = '0;
        run_best_x = -1;
        run_best_y = -1;
        scan_open  = 1'b0;
        centre_x   = '0;
        centre_y   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scan();
        test_view_products();
        test_open_scan();
        test_count_saturation();
        test_centre_extremes();
        test_backpressure();
        test_random();

        wait_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
